FILE: src/rgb_to_hsv_convert_macros.svh
// ---------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_MACROS_SVH
`define RGB_TO_HSV_CONVERT_MACROS_SVH

// same-cycle implication, off during reset
`define RHC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always checked
`define RHC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rhc_pkg.sv
// ---------------------------------------------------------------------------
// rgb to hsv converter package
// shared types and constants for the front, queue and divide pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   // hue sector, picked by the largest channel
   localparam logic [1:0] SECT_RED   = 2'd0;
   localparam logic [1:0] SECT_GREEN = 2'd1;
   localparam logic [1:0] SECT_BLUE  = 2'd2;

   localparam logic [14:0] HUE_GREEN_BASE = 15'd7680;
   localparam logic [14:0] HUE_BLUE_BASE  = 15'd15360;
   localparam logic [14:0] HUE_FULL_TURN  = 15'd23040;

   localparam int HUE_SIXTY       = 3840;
   localparam int HUE_RECIP_SHIFT = 12;
   localparam int SAT_RECIP_SHIFT = 24;

   typedef struct packed {
      logic [7:0] max_val;
      logic [7:0] delta;
      logic [7:0] abs_diff;
      logic       diff_neg;
      logic [1:0] sector;
      logic       gray;
   } class_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [7:0]  brightness;
   } result_type;

endpackage

`default_nettype wire

FILE: src/rgb_to_hsv_convert.sv
// ---------------------------------------------------------------------------
// rgb to hsv converter
// 8-bit pixel in, hue in 1/64 degree, 16-bit saturation and 8-bit value out
// ---------------------------------------------------------------------------
// Converts one pixel per clock, sustained, while neither side stalls. A pixel
// accepted on the request queue passes the classify stage and the middle queue,
// then the four stages of the divide pipeline (reciprocal table, estimate
// multiply, back multiply, remainder correction), whose last stage writes
// straight into the output queue, before it shows on the response queue.
// Both divisions are exact, done as a reciprocal multiply with one correction
// step. Either side may stall at will; the middle and output queues (MidDepth,
// OutDepth, two or more) decouple them.
`default_nettype none

module rgb_to_hsv_convert
   import rhc_pkg::*;
#(
   parameter int MidDepth = MID_DEPTH,
   parameter int OutDepth = OUT_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_blue,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_red,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic      [14:0] rsp_hue,
   output logic      [15:0] rsp_saturation,
   output logic      [7:0]  rsp_brightness
);

   logic       mid_push, mid_full, mid_pop, mid_empty;
   class_type  mid_wdata, mid_rdata;
   logic       out_push, out_full;
   result_type out_wdata, out_rdata;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_blue  (req_blue),
      .req_green (req_green),
      .req_red   (req_red),
      .mid_push  (mid_push),
      .mid_full  (mid_full),
      .mid_data  (mid_wdata)
   );

   rhc_fifo #(
      .Width ($bits(class_type)),
      .Depth (MidDepth)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .full  (mid_full),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .empty (mid_empty),
      .rdata (mid_rdata)
   );

   rhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_data  (mid_rdata),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   rhc_fifo #(
      .Width ($bits(result_type)),
      .Depth (OutDepth)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (out_rdata)
   );

   assign rsp_hue        = out_rdata.hue;
   assign rsp_saturation = out_rdata.saturation;
   assign rsp_brightness = out_rdata.brightness;

endmodule

`default_nettype wire

FILE: src/rhc_fifo.sv
// ---------------------------------------------------------------------------
// rgb to hsv small queue
// register-based first-in first-out queue, depth of two or more
// ---------------------------------------------------------------------------
`default_nettype none

module rhc_fifo #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [Width-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [Width-1:0] rdata
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: src/rhc_front.sv
// ---------------------------------------------------------------------------
// rgb to hsv front stage
// takes a pixel, finds max, min, hue sector and signed channel difference
// ---------------------------------------------------------------------------
`default_nettype none

module rhc_front
   import rhc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_red,
   output logic            mid_push,
   input  wire logic       mid_full,
   output class_type       mid_data
);

   logic      valid_ff, valid_in;
   class_type item_ff, item_in, item_new;
   logic      accept;
   logic [7:0] mx, mn, opa, opb;

   always_comb begin
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx)  mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn)  mn = req_blue;

      // ties go to red first, then green
      priority if (mx == req_red) begin
         item_new.sector = SECT_RED;
         opa = req_green;
         opb = req_blue;
      end else if (mx == req_green) begin
         item_new.sector = SECT_GREEN;
         opa = req_blue;
         opb = req_red;
      end else begin
         item_new.sector = SECT_BLUE;
         opa = req_red;
         opb = req_green;
      end

      item_new.max_val  = mx;
      item_new.delta    = mx - mn;
      item_new.gray     = (mx == mn);
      item_new.diff_neg = (opa < opb);
      item_new.abs_diff = (opa < opb) ? (opb - opa) : (opa - opb);
   end

   assign req_full = valid_ff && mid_full;
   assign accept   = req_push && !req_full;
   assign mid_push = valid_ff && !mid_full;
   assign mid_data = item_ff;

   always_comb begin
      valid_in = accept || (valid_ff && !mid_push);
      item_in  = accept ? item_new : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

FILE: src/rhc_back.sv
// ---------------------------------------------------------------------------
// rgb to hsv divide pipeline
// four stages: reciprocal lookup, estimate multiply, back multiply, correction
// ---------------------------------------------------------------------------
`default_nettype none

module rhc_back
   import rhc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic mid_empty,
   output logic      mid_pop,
   input  wire class_type mid_data,
   input  wire logic out_full,
   output logic      out_push,
   output result_type out_data
);

   // reciprocal tables, floor(3840 * 2^12 / d) and floor(2^24 / d)
   logic [23:0] hue_recip [256];
   logic [24:0] sat_recip [256];

   for (genvar i = 0; i < 256; i++) begin : g_recip
      localparam longint unsigned Den = (i == 0) ? 1 : i;
      localparam longint unsigned HueR =
         (longint'(HUE_SIXTY) << HUE_RECIP_SHIFT) / Den;
      localparam longint unsigned SatR = (64'd1 << SAT_RECIP_SHIFT) / Den;
      assign hue_recip[i] = 24'(HueR);
      assign sat_recip[i] = 25'(SatR);
   end

   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in, s4_v_ff, s4_v_in;
   logic rdy1, rdy2, rdy3, rdy4;

   class_type   s1_item_ff, s2_item_ff, s3_item_ff;
   logic [23:0] s1_rh_ff;
   logic [24:0] s1_rs_ff;
   logic [11:0] s2_qh_ff, s3_qh_ff;
   logic [16:0] s2_qs_ff, s3_qs_ff;
   logic [19:0] s3_ph_ff;
   logic [24:0] s3_ps_ff;
   result_type  s4_res_ff, s4_res_in;

   logic [31:0] est_h;
   logic [32:0] est_s;
   logic [19:0] back_h;
   logic [24:0] back_s;
   logic [19:0] num_h, rem_h;
   logic [24:0] num_s, rem_s;
   logic [11:0] qh_fix;
   logic [16:0] qs_fix;
   logic [14:0] base, base_eff;

   assign rdy4     = !s4_v_ff || !out_full;
   assign rdy3     = !s3_v_ff || rdy4;
   assign rdy2     = !s2_v_ff || rdy3;
   assign rdy1     = !s1_v_ff || rdy2;
   assign mid_pop  = rdy1 && !mid_empty;
   assign out_push = s4_v_ff && !out_full;
   assign out_data = s4_res_ff;

   always_comb begin
      s1_v_in = rdy1 ? !mid_empty : s1_v_ff;
      s2_v_in = rdy2 ? s1_v_ff : s2_v_ff;
      s3_v_in = rdy3 ? s2_v_ff : s3_v_ff;
      s4_v_in = rdy4 ? s3_v_ff : s4_v_ff;
   end

   // quotient estimates, each low by at most one
   always_comb begin
      est_h = {24'd0, s1_item_ff.abs_diff} * {8'd0, s1_rh_ff};
      est_s = {25'd0, s1_item_ff.delta} * {8'd0, s1_rs_ff};
   end

   always_comb begin
      back_h = {8'd0, s2_qh_ff} * {12'd0, s2_item_ff.delta};
      back_s = {8'd0, s2_qs_ff} * {17'd0, s2_item_ff.max_val};
   end

   always_comb begin
      num_h  = {12'd0, s3_item_ff.abs_diff} * 20'(HUE_SIXTY);
      rem_h  = num_h - s3_ph_ff;
      qh_fix = s3_qh_ff + 12'(rem_h >= {12'd0, s3_item_ff.delta});
      num_s  = {1'b0, s3_item_ff.delta, 16'd0};
      rem_s  = num_s - s3_ps_ff;
      qs_fix = s3_qs_ff + 17'(rem_s >= {17'd0, s3_item_ff.max_val});

      unique case (s3_item_ff.sector)
         SECT_GREEN: base = HUE_GREEN_BASE;
         SECT_BLUE:  base = HUE_BLUE_BASE;
         default:    base = '0;
      endcase
      // negative red hue wraps round a full turn
      base_eff = (s3_item_ff.sector == SECT_RED && s3_item_ff.diff_neg && qh_fix != '0)
                 ? HUE_FULL_TURN : base;

      s4_res_in.brightness = s3_item_ff.max_val;
      if (s3_item_ff.gray) begin
         s4_res_in.hue        = '0;
         s4_res_in.saturation = '0;
      end else begin
         s4_res_in.hue = s3_item_ff.diff_neg ? (base_eff - {3'd0, qh_fix})
                                              : (base_eff + {3'd0, qh_fix});
         s4_res_in.saturation = qs_fix[16] ? 16'hFFFF : qs_fix[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_item_ff <= mid_data;
         s1_rh_ff   <= hue_recip[mid_data.delta];
         s1_rs_ff   <= sat_recip[mid_data.max_val];
      end
      if (rdy2) begin
         s2_item_ff <= s1_item_ff;
         s2_qh_ff   <= est_h[23:12];
         s2_qs_ff   <= est_s[24:8];
      end
      if (rdy3) begin
         s3_item_ff <= s2_item_ff;
         s3_qh_ff   <= s2_qh_ff;
         s3_qs_ff   <= s2_qs_ff;
         s3_ph_ff   <= back_h;
         s3_ps_ff   <= back_s;
      end
      if (rdy4) begin
         s4_res_ff <= s4_res_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/rhc_checker.sv
// ---------------------------------------------------------------------------
// rgb to hsv converter checker
// port-level assertions, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hsv_convert_macros.svh"

module rhc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [14:0] rsp_hue,
   input wire logic [15:0] rsp_saturation,
   input wire logic [7:0]  rsp_brightness
);

   // both queues come out of reset empty
   `RHC_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, rsp_empty && !req_full,
      "queues not empty after reset")

   `RHC_ASSERT_IMPLY(a_hue_range, clock, reset, !rsp_empty, rsp_hue < 15'd23040,
      "hue beyond full turn")

   // a black pixel is gray: no hue, no saturation
   `RHC_ASSERT_IMPLY(a_black_gray, clock, reset, !rsp_empty && rsp_brightness == 8'd0,
      rsp_hue == 15'd0 && rsp_saturation == 16'd0, "black pixel with colour")

   `RHC_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_hue) && $stable(rsp_saturation) && $stable(rsp_brightness),
      "stalled beat changed")

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_brightness (rsp_brightness)
);

`default_nettype wire

FILE: tb/tb_rgb_to_hsv_convert.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb to hsv converter testbench
// drives pixels through the request queue and checks hue, saturation and
// value on each response beat against an in-bench integer predictor, with
// directed corner pixels, then random pixels under several idle mixes
// ---------------------------------------------------------------------------

module tb_rgb_to_hsv_convert;

   localparam int HueSixty      = 3840;
   localparam int HueGreenStart = 7680;
   localparam int HueBlueStart  = 15360;
   localparam int HueFullTurn   = 23040;
   localparam int SatCeiling    = 65535;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles   = 16;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [7:0]  brightness;
   } hsv_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_blue = 8'd0;
   logic [7:0]  req_green = 8'd0;
   logic [7:0]  req_red = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [14:0] rsp_hue;
   logic [15:0] rsp_saturation;
   logic [7:0]  rsp_brightness;

   hsv_type hsv_expected[$];
   int   mismatch_count = 0;
   int   send_idle_pct = 0;
   int   pop_stall_pct = 0;
   int   quiet_cycles = 0;

   rgb_to_hsv_convert dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic hsv_type predict_hsv(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
      int   ib, ig, ir, hi, lo, spread, start, diff, hue_val;
      longint sat_val;
      hsv_type res;
      ib = int'(b);
      ig = int'(g);
      ir = int'(r);
      hi = ir;
      lo = ir;
      if (ig > hi) hi = ig;
      if (ib > hi) hi = ib;
      if (ig < lo) lo = ig;
      if (ib < lo) lo = ib;
      spread = hi - lo;
      hue_val = 0;
      sat_val = 0;
      if (spread != 0) begin
         // ties go to red first, then green
         if (hi == ir) begin
            start = 0;
            diff = ig - ib;
         end else if (hi == ig) begin
            start = HueGreenStart;
            diff = ib - ir;
         end else begin
            start = HueBlueStart;
            diff = ir - ig;
         end
         // int division truncates toward zero
         hue_val = start + (HueSixty * diff) / spread;
         if (hue_val < 0) hue_val += HueFullTurn;
         sat_val = (longint'(spread) << 16) / longint'(hi);
         if (sat_val > longint'(SatCeiling)) sat_val = longint'(SatCeiling);
      end
      res.hue        = hue_val[14:0];
      res.saturation = sat_val[15:0];
      res.brightness = hi[7:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // predict on each request beat, check on each response beat
   always @(posedge clock) begin
      hsv_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (hsv_expected.size() == 0) begin
            report_mismatch("unexpected response", int'(rsp_hue), 0);
         end else begin
            want = hsv_expected.pop_front();
            if (rsp_hue !== want.hue)
               report_mismatch("hue", int'(rsp_hue), int'(want.hue));
            if (rsp_saturation !== want.saturation)
               report_mismatch("saturation", int'(rsp_saturation), int'(want.saturation));
            if (rsp_brightness !== want.brightness)
               report_mismatch("brightness", int'(rsp_brightness), int'(want.brightness));
         end
      end
      if (!reset && req_push && !req_full)
         hsv_expected.insert(hsv_expected.size(), predict_hsv(req_blue, req_green, req_red));
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("[%0t] no beat for %0d cycles", $realtime, quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push  <= 1'b1;
      req_blue  <= b;
      req_green <= g;
      req_red   <= r;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic test_extremes();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      req_push <= 1'b0;
   endtask

   task automatic test_sectors_and_ties();
      send_pixel(8'd50,  8'd0,   8'd255);   // red largest, hue wraps past zero
      send_pixel(8'd1,   8'd0,   8'd255);   // red largest, tiny negative offset
      send_pixel(8'd30,  8'd90,  8'd200);
      send_pixel(8'd40,  8'd180, 8'd70);
      send_pixel(8'd100, 8'd180, 8'd120);
      send_pixel(8'd220, 8'd10,  8'd60);
      send_pixel(8'd220, 8'd60,  8'd10);
      send_pixel(8'd10,  8'd200, 8'd200);   // red and green tie
      send_pixel(8'd200, 8'd200, 8'd10);    // green and blue tie
      send_pixel(8'd200, 8'd10,  8'd200);   // red and blue tie
      req_push <= 1'b0;
   endtask

   task automatic test_gray_and_saturation();
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd0,   8'd0,   8'd1);    // smallest channel zero
      send_pixel(8'd0,   8'd77,  8'd143);
      send_pixel(8'd254, 8'd255, 8'd254);
      send_pixel(8'd170, 8'd85,  8'd255);
      req_push <= 1'b0;
   endtask

   task automatic send_random_pixel();
      logic [7:0] b, g, r;
      b = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      r = 8'($urandom_range(255));
      case ($urandom_range(9))
         0: begin
            g = b;
            r = b;
         end
         1: if ($urandom_range(1)) r = g; else g = b;
         2: if ($urandom_range(1)) b = 8'd0; else r = 8'd0;
         3: if ($urandom_range(1)) g = 8'd255; else r = 8'd255;
         4: begin
            b = 8'($urandom_range(3));
            g = 8'($urandom_range(3));
            r = 8'($urandom_range(3));
         end
         default: ;
      endcase
      send_pixel(b, g, r);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (count) send_random_pixel();
      req_push <= 1'b0;
   endtask

   // sender holds off until every response is back, then bursts again
   task automatic test_pause_until_drained();
      pop_stall_pct = 53;
      send_idle_pct = 0;
      repeat (20) send_random_pixel();
      req_push <= 1'b0;
      while (hsv_expected.size() != 0) @(negedge clock);
      repeat (20) send_random_pixel();
      req_push <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_sectors_and_ties();
      test_gray_and_saturation();
      test_random_traffic(450, 0, 0);
      test_random_traffic(450, 53, 0);
      test_pause_until_drained();
      test_random_traffic(450, 0, 53);
      test_random_traffic(450, 15, 15);
      pop_stall_pct = 0;
      while (hsv_expected.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
